FILE: sv/i64alu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i64alu_pkg
// Shared op codes, widths and the pipeline tag for the 64-bit integer ALU.
// ----------------------------------------------------------------------------
package i64alu_pkg;

    localparam int DATA_W     = 64;
    localparam int HALF_W     = DATA_W / 2;
    localparam int OP_W       = 5;
    localparam int DIV_STAGES = DATA_W;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 5'd0,
        OP_SUB = 5'd1,
        OP_MUL = 5'd2,
        OP_DIV = 5'd3,
        OP_MOD = 5'd4,
        OP_NEG = 5'd5,
        OP_ABS = 5'd6,
        OP_EQ  = 5'd7,
        OP_NE  = 5'd8,
        OP_LT  = 5'd9,
        OP_LE  = 5'd10,
        OP_GT  = 5'd11,
        OP_GE  = 5'd12,
        OP_NOT = 5'd13,
        OP_AND = 5'd14,
        OP_OR  = 5'd15,
        OP_XOR = 5'd16
    } t_op;

    // Control that travels alongside each item through the pipe.
    typedef struct packed {
        logic vld;
        logic is_div;
        logic is_mod;
        logic neg_q;
        logic neg_r;
        logic dz;
        logic last;
    } t_tag;

endpackage
`default_nettype wire

FILE: sv/int64_elementwise_alu_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// int64_elementwise_alu_top
// Streaming 64-bit integer ALU: arithmetic, divide, compare and bitwise ops.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries op, two signed operands and a
//   last mark; output channel (o_valid/i_ready) returns one result per item
//   with a divide-by-zero flag and the copied last mark, in order.
//   The pipe is two front stages (decode, simple ops, 32x32
//   partial products, product sum), 64 divider stages resolving one quotient
//   bit each, and one output register. Every op takes the full path, so
//   results never reorder.
//   Throughput is one item per cycle while not stalled; the pipe advances
//   as a whole whenever the output register is empty or its transfer
//   completes this cycle. When the receiver stalls with a result waiting,
//   the whole pipe holds, o_ready drops and nothing is lost or repeated.
//   Reset clears all stage valid bits; no result is shown after reset until
//   an item has traveled the pipe.
// ----------------------------------------------------------------------------
module int64_elementwise_alu_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [i64alu_pkg::OP_W-1:0]    i_op,
    input  wire logic [i64alu_pkg::DATA_W-1:0]  i_operand_a,
    input  wire logic [i64alu_pkg::DATA_W-1:0]  i_operand_b,
    input  wire logic                           i_last_in,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic      [i64alu_pkg::DATA_W-1:0]  o_result_value,
    output logic                                o_divide_by_zero,
    output logic                                o_last_out
);
    import i64alu_pkg::*;

    logic              s_en;
    t_tag              s_prep_tag;
    logic [DATA_W-1:0] s_prep_early;
    logic [DATA_W-1:0] s_ua;
    logic [DATA_W-1:0] s_ub;
    t_tag              s_div_tag;
    logic [DATA_W-1:0] s_div_early;
    logic [DATA_W-1:0] s_q;
    logic [DATA_W-1:0] s_r;

    // Global advance: output slot free or being drained this cycle.
    assign s_en    = ~o_valid | i_ready;
    assign o_ready = s_en;

    i64alu_prep u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (s_en),
        .i_valid     (i_valid),
        .i_op        (i_op),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .i_last_in   (i_last_in),
        .o_tag       (s_prep_tag),
        .o_early     (s_prep_early),
        .o_ua        (s_ua),
        .o_ub        (s_ub)
    );

    i64alu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_tag   (s_prep_tag),
        .i_early (s_prep_early),
        .i_ua    (s_ua),
        .i_ub    (s_ub),
        .o_tag   (s_div_tag),
        .o_early (s_div_early),
        .o_q     (s_q),
        .o_r     (s_r)
    );

    i64alu_post u_post (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (s_en),
        .i_tag            (s_div_tag),
        .i_early          (s_div_early),
        .i_q              (s_q),
        .i_r              (s_r),
        .o_valid          (o_valid),
        .o_result_value   (o_result_value),
        .o_divide_by_zero (o_divide_by_zero),
        .o_last_out       (o_last_out)
    );

`ifndef SYNTH
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_by_zero |-> o_result_value == '0)
        else $error("divide-by-zero result not zero");

    a_dz_only_divmod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_div_tag.dz |-> (s_div_tag.is_div || s_div_tag.is_mod))
        else $error("divide-by-zero flag on non-divide op");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("pipe advance mismatch");
`endif

endmodule
`default_nettype wire

FILE: sv/i64alu_prep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i64alu_prep
// Two front stages: decode, simple ops, partial products, then product sum.
// ----------------------------------------------------------------------------
module i64alu_prep (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic                           i_valid,
    input  wire logic [i64alu_pkg::OP_W-1:0]    i_op,
    input  wire logic [i64alu_pkg::DATA_W-1:0]  i_operand_a,
    input  wire logic [i64alu_pkg::DATA_W-1:0]  i_operand_b,
    input  wire logic                           i_last_in,
    output i64alu_pkg::t_tag                    o_tag,
    output logic      [i64alu_pkg::DATA_W-1:0]  o_early,
    output logic      [i64alu_pkg::DATA_W-1:0]  o_ua,
    output logic      [i64alu_pkg::DATA_W-1:0]  o_ub
);
    import i64alu_pkg::*;

    logic [DATA_W-1:0] s_simple;
    logic [DATA_W-1:0] s_neg_a;
    logic [DATA_W-1:0] s_neg_b;
    logic              s_lt;
    logic              s_gt;
    logic              s_eq;
    t_tag              s_tag;

    t_tag              r1_tag;
    logic              r1_is_mul;
    logic [DATA_W-1:0] r1_simple;
    logic [DATA_W-1:0] r1_ua;
    logic [DATA_W-1:0] r1_ub;
    logic [DATA_W-1:0] r1_p0;
    logic [HALF_W-1:0] r1_p1;
    logic [HALF_W-1:0] r1_p2;
    logic [DATA_W-1:0] s_mul;

    t_tag              r2_tag;
    logic [DATA_W-1:0] r2_early;
    logic [DATA_W-1:0] r2_ua;
    logic [DATA_W-1:0] r2_ub;

    assign s_neg_a = '0 - i_operand_a;
    assign s_neg_b = '0 - i_operand_b;
    assign s_eq    = (i_operand_a == i_operand_b);
    assign s_lt    = ($signed(i_operand_a) < $signed(i_operand_b));
    assign s_gt    = ($signed(i_operand_b) < $signed(i_operand_a));

    always_comb begin
        case (i_op)
            OP_ADD:  s_simple = i_operand_a + i_operand_b;
            OP_SUB:  s_simple = i_operand_a - i_operand_b;
            OP_NEG:  s_simple = s_neg_a;
            OP_ABS:  s_simple = i_operand_a[DATA_W-1] ? s_neg_a : i_operand_a;
            OP_EQ:   s_simple = {DATA_W{s_eq}};
            OP_NE:   s_simple = {DATA_W{~s_eq}};
            OP_LT:   s_simple = {DATA_W{s_lt}};
            OP_LE:   s_simple = {DATA_W{~s_gt}};
            OP_GT:   s_simple = {DATA_W{s_gt}};
            OP_GE:   s_simple = {DATA_W{~s_lt}};
            OP_NOT:  s_simple = ~i_operand_a;
            OP_AND:  s_simple = i_operand_a & i_operand_b;
            OP_OR:   s_simple = i_operand_a | i_operand_b;
            OP_XOR:  s_simple = i_operand_a ^ i_operand_b;
            default: s_simple = '0;
        endcase
    end

    always_comb begin
        s_tag        = '0;
        s_tag.vld    = i_valid;
        s_tag.is_div = (i_op == OP_DIV);
        s_tag.is_mod = (i_op == OP_MOD);
        s_tag.neg_q  = i_operand_a[DATA_W-1] ^ i_operand_b[DATA_W-1];
        s_tag.neg_r  = i_operand_a[DATA_W-1];
        s_tag.dz     = (s_tag.is_div | s_tag.is_mod) & (i_operand_b == '0);
        s_tag.last   = i_last_in;
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag <= '0;
        end else if (i_en) begin
            r1_tag <= s_tag;
        end
    end

    // low x low partial: both factors zero-extended, so a 32x32 product
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_is_mul <= (i_op == OP_MUL);
            r1_simple <= s_simple;
            r1_ua     <= i_operand_a[DATA_W-1] ? s_neg_a : i_operand_a;
            r1_ub     <= i_operand_b[DATA_W-1] ? s_neg_b : i_operand_b;
            r1_p0     <= {{HALF_W{1'b0}}, i_operand_a[HALF_W-1:0]} *
                         {{HALF_W{1'b0}}, i_operand_b[HALF_W-1:0]};
            r1_p1     <= HALF_W'(i_operand_a[HALF_W-1:0] * i_operand_b[DATA_W-1:HALF_W]);
            r1_p2     <= HALF_W'(i_operand_a[DATA_W-1:HALF_W] * i_operand_b[HALF_W-1:0]);
        end
    end

    // low half of the 64x64 product from the three partials
    assign s_mul = r1_p0 + {r1_p1 + r1_p2, {HALF_W{1'b0}}};

    // stage 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_tag <= '0;
        end else if (i_en) begin
            r2_tag <= r1_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_early <= r1_is_mul ? s_mul : r1_simple;
            r2_ua    <= r1_ua;
            r2_ub    <= r1_ub;
        end
    end

    assign o_tag   = r2_tag;
    assign o_early = r2_early;
    assign o_ua    = r2_ua;
    assign o_ub    = r2_ub;

endmodule
`default_nettype wire

FILE: sv/i64alu_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i64alu_div
// Restoring unsigned divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module i64alu_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire i64alu_pkg::t_tag               i_tag,
    input  wire logic [i64alu_pkg::DATA_W-1:0]  i_early,
    input  wire logic [i64alu_pkg::DATA_W-1:0]  i_ua,
    input  wire logic [i64alu_pkg::DATA_W-1:0]  i_ub,
    output i64alu_pkg::t_tag                    o_tag,
    output logic      [i64alu_pkg::DATA_W-1:0]  o_early,
    output logic      [i64alu_pkg::DATA_W-1:0]  o_q,
    output logic      [i64alu_pkg::DATA_W-1:0]  o_r
);
    import i64alu_pkg::*;

    t_tag              r_tag   [DIV_STAGES];
    logic [DATA_W-1:0] r_early [DIV_STAGES];
    logic [DATA_W-1:0] r_rem   [DIV_STAGES];
    logic [DATA_W-1:0] r_quo   [DIV_STAGES];
    logic [DATA_W-1:0] r_ub    [DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++) begin : g_stage
            t_tag              s_tag;
            logic [DATA_W-1:0] s_early;
            logic [DATA_W-1:0] s_rem;
            logic [DATA_W-1:0] s_quo;
            logic [DATA_W-1:0] s_ub;
            logic [DATA_W:0]   s_shift;
            logic [DATA_W:0]   s_diff;
            logic [DATA_W-1:0] n_rem;
            logic [DATA_W-1:0] n_quo;

            if (k == 0) begin : g_first
                assign s_tag   = i_tag;
                assign s_early = i_early;
                assign s_rem   = '0;
                assign s_quo   = i_ua;
                assign s_ub    = i_ub;
            end else begin : g_next
                assign s_tag   = r_tag[k-1];
                assign s_early = r_early[k-1];
                assign s_rem   = r_rem[k-1];
                assign s_quo   = r_quo[k-1];
                assign s_ub    = r_ub[k-1];
            end

            assign s_shift = {s_rem, s_quo[DATA_W-1]};
            assign s_diff  = s_shift - {1'b0, s_ub};

            always_comb begin
                if (!s_diff[DATA_W]) begin
                    n_rem = s_diff[DATA_W-1:0];
                    n_quo = {s_quo[DATA_W-2:0], 1'b1};
                end else begin
                    n_rem = s_shift[DATA_W-1:0];
                    n_quo = {s_quo[DATA_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_tag[k] <= '0;
                end else if (i_en) begin
                    r_tag[k] <= s_tag;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_early[k] <= s_early;
                    r_rem[k]   <= n_rem;
                    r_quo[k]   <= n_quo;
                    r_ub[k]    <= s_ub;
                end
            end
        end
    endgenerate

    assign o_tag   = r_tag[DIV_STAGES-1];
    assign o_early = r_early[DIV_STAGES-1];
    assign o_q     = r_quo[DIV_STAGES-1];
    assign o_r     = r_rem[DIV_STAGES-1];

endmodule
`default_nettype wire

FILE: sv/i64alu_post.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i64alu_post
// Sign fixup of quotient/remainder, zero-divisor override, output register.
// ----------------------------------------------------------------------------
module i64alu_post (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire i64alu_pkg::t_tag               i_tag,
    input  wire logic [i64alu_pkg::DATA_W-1:0]  i_early,
    input  wire logic [i64alu_pkg::DATA_W-1:0]  i_q,
    input  wire logic [i64alu_pkg::DATA_W-1:0]  i_r,
    output logic                                o_valid,
    output logic      [i64alu_pkg::DATA_W-1:0]  o_result_value,
    output logic                                o_divide_by_zero,
    output logic                                o_last_out
);
    import i64alu_pkg::*;

    logic [DATA_W-1:0] n_res;
    logic              r_vld;
    logic [DATA_W-1:0] r_res;
    logic              r_dz;
    logic              r_last;

    always_comb begin
        if (i_tag.dz) begin
            n_res = '0;
        end else if (i_tag.is_div) begin
            n_res = i_tag.neg_q ? ('0 - i_q) : i_q;
        end else if (i_tag.is_mod) begin
            n_res = i_tag.neg_r ? ('0 - i_r) : i_r;
        end else begin
            n_res = i_early;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_tag.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res  <= n_res;
            r_dz   <= i_tag.dz;
            r_last <= i_tag.last;
        end
    end

    assign o_valid          = r_vld;
    assign o_result_value   = r_res;
    assign o_divide_by_zero = r_dz;
    assign o_last_out       = r_last;

endmodule
`default_nettype wire
